/* rtl/ihe_pkg.sv */
// shared constants and controller/datapath interface types for the entropy block
package ihe_pkg;

  localparam int BIN_COUNT_DEF       = 256;
  localparam int MAX_PIXELS_LOG2_DEF = 20;
  localparam int FRACTION_BITS_DEF   = 16;

  localparam int PIX_W       = 8;
  localparam int LOG_FRAC    = 30;
  localparam int MANT_W      = 32;
  localparam int ENT_W       = 20;
  localparam int TOT_W       = 21;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ENT_W - TOT_W;
  localparam logic [ENT_W-1:0] ENT_MAX = {ENT_W{1'b1}};

  typedef struct packed {
    logic pix_en;
    logic idx_clr;
    logic idx_inc;
    logic latch_c;
    logic log_start;
    logic log_sel_n;
    logic save_logn;
    logic mul_frac;
    logic mul_int;
    logic acc_add;
    logic acc_clr;
    logic div_start;
    logic out_load;
    logic frame_clr;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic pipe_busy;
    logic n_zero;
    logic bin_zero;
    logic idx_last;
    logic log_done;
    logic div_done;
    logic out_full;
  } sts_t;

endpackage

/* rtl/ihe_log2.sv */
// iterative fixed-point log2: normalize one bit a cycle, then one squaring per fraction bit
module ihe_log2 #(
  parameter int CNT_W = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [CNT_W-1:0]              x_i,
  output logic                          done_o,
  output logic [$clog2(CNT_W)-1:0]      e_o,
  output logic [ihe_pkg::LOG_FRAC-1:0]  frac_o
);
  import ihe_pkg::*;

  localparam int LOGE_W = $clog2(CNT_W);
  localparam int K_W    = $clog2(LOG_FRAC);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} phase_e;

  phase_e              phase_q;
  logic [MANT_W-1:0]   m_q;
  logic [LOGE_W-1:0]   e_q;
  logic [LOG_FRAC-1:0] frac_q;
  logic [K_W-1:0]      k_q;
  logic                done_q;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     t;

  assign sq = m_q * m_q;
  assign t  = sq[2*MANT_W-1:MANT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= L_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        L_IDLE: begin
          if (start_i) begin
            phase_q <= L_NORM;
            k_q     <= '0;
          end
        end
        L_NORM: begin
          if (m_q[MANT_W-1]) phase_q <= L_SQ;
        end
        L_SQ: begin
          k_q <= k_q + K_W'(1);
          if (k_q == K_W'(LOG_FRAC - 1)) begin
            phase_q <= L_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: phase_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == L_IDLE && start_i) begin
      m_q    <= {x_i, {(MANT_W-CNT_W){1'b0}}};
      e_q    <= LOGE_W'(CNT_W - 1);
      frac_q <= '0;
    end else if (phase_q == L_NORM && !m_q[MANT_W-1]) begin
      m_q <= {m_q[MANT_W-2:0], 1'b0};
      e_q <= e_q - LOGE_W'(1);
    end else if (phase_q == L_SQ) begin
      m_q    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      frac_q <= {frac_q[LOG_FRAC-2:0], t[MANT_W]};
    end
  end

  assign done_o = done_q;
  assign e_o    = e_q;
  assign frac_o = frac_q;

endmodule

/* rtl/ihe_div.sv */
// restoring divider, one quotient bit per cycle
module ihe_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  import ihe_pkg::*;

  localparam int C_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [C_W-1:0]   cnt_q;
  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] r_q;
  logic [DEN_W-1:0] d_q;
  logic [DEN_W:0]   r_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign r_sh = {r_q, q_q[NUM_W-1]};
  assign ge   = r_sh >= {1'b0, d_q};
  assign diff = r_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - C_W'(1);
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
      q_q <= {q_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

/* rtl/ihe_dp.sv */
// datapath: histogram memory with forwarding, log/multiply/accumulate, divider, output register
module ihe_dp #(
  parameter int BIN_COUNT       = ihe_pkg::BIN_COUNT_DEF,
  parameter int MAX_PIXELS_LOG2 = ihe_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int FRACTION_BITS   = ihe_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ihe_pkg::cmd_t                    cmd_i,
  output ihe_pkg::sts_t                    sts_o,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ihe_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ihe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tuser_o
);
  import ihe_pkg::*;

  localparam int BIN_W  = $clog2(BIN_COUNT);
  localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
  localparam int LOGE_W = $clog2(CNT_W);
  localparam int LOG_W  = LOGE_W + LOG_FRAC;
  localparam int SUM_W  = CNT_W + LOG_W;
  localparam int RSH    = LOG_FRAC - FRACTION_BITS;
  localparam int PF_W   = CNT_W + LOG_FRAC;
  localparam int PI_W   = CNT_W + LOGE_W;

  // pixel intake
  logic                accept;
  logic                count_it;
  logic [PIX_W:0]      pix_ext;
  logic [BIN_W-1:0]    pix_bin;
  logic [CNT_W-1:0]    cnt_q;
  logic                ovf_q;

  assign accept   = cmd_i.pix_en & s_axis_tvalid_i;
  assign count_it = accept & ~cnt_q[CNT_W-1];
  assign pix_ext  = {1'b0, s_axis_tdata_i[PIX_W-1:0]};
  assign pix_bin  = (pix_ext >= (PIX_W+1)'(BIN_COUNT)) ? BIN_W'(BIN_COUNT - 1)
                                                       : pix_ext[BIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.frame_clr) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (count_it) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (accept) begin
      ovf_q <= 1'b1;
    end
  end

  // histogram memory, valid bits and read-modify-write forwarding
  logic [CNT_W-1:0]     mem_q [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld_q;
  logic [BIN_W-1:0]     idx_q;
  logic [BIN_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     rd_q;
  logic                 rd_vld_q;
  logic                 p1_vld_q;
  logic [BIN_W-1:0]     p1_addr_q;
  logic                 fw_vld_q;
  logic [BIN_W-1:0]     fw_addr_q;
  logic [CNT_W-1:0]     fw_cnt_q;
  logic [CNT_W-1:0]     old_cnt;
  logic [CNT_W-1:0]     new_cnt;
  logic [CNT_W-1:0]     bin_cnt;

  assign rd_addr = cmd_i.pix_en ? pix_bin : idx_q;
  assign old_cnt = (fw_vld_q && fw_addr_q == p1_addr_q) ? fw_cnt_q
                 : (rd_vld_q ? rd_q : '0);
  assign new_cnt = old_cnt + CNT_W'(1);
  assign bin_cnt = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (p1_vld_q) mem_q[p1_addr_q] <= new_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      fw_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      p1_vld_q <= count_it;
      if (cmd_i.frame_clr) begin
        vld_q    <= '0;
        fw_vld_q <= 1'b0;
      end else if (p1_vld_q) begin
        vld_q[p1_addr_q] <= 1'b1;
        fw_vld_q         <= 1'b1;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + BIN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q <= pix_bin;
    if (p1_vld_q) begin
      fw_addr_q <= p1_addr_q;
      fw_cnt_q  <= new_cnt;
    end
  end

  // entropy sum
  logic [CNT_W-1:0]    c_q;
  logic [CNT_W-1:0]    log_x;
  logic                log_done;
  logic [LOGE_W-1:0]   log_e;
  logic [LOG_FRAC-1:0] log_frac;
  logic [LOG_W-1:0]    logn_q;
  logic [PF_W-1:0]     pf;
  logic [PI_W-1:0]     pi;
  logic [SUM_W-1:0]    prod_q;
  logic [SUM_W-1:0]    acc_q;
  logic                div_done;
  logic [SUM_W-1:0]    quo;

  assign log_x = cmd_i.log_sel_n ? cnt_q : bin_cnt;
  assign pf    = c_q * log_frac;
  assign pi    = c_q * log_e;

  ihe_log2 #(.CNT_W(CNT_W)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .e_o     (log_e),
    .frac_o  (log_frac)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_c) c_q <= bin_cnt;
    if (cmd_i.save_logn) logn_q <= {log_e, log_frac};
    if (cmd_i.mul_frac) prod_q <= SUM_W'(pf);
    else if (cmd_i.mul_int) prod_q <= {pi, {LOG_FRAC{1'b0}}};
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + prod_q;
  end

  ihe_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // final difference, rounding and clamp
  logic [LOG_W-1:0]   d;
  logic [LOG_W:0]     r_wide;
  logic [ENT_W-1:0]   ent;
  logic [TOT_W+CNT_W-1:0] tot_ext;

  assign d       = (quo >= SUM_W'(logn_q)) ? '0 : (logn_q - quo[LOG_W-1:0]);
  assign r_wide  = ({1'b0, d} + ((LOG_W+1)'(1) << (RSH - 1))) >> RSH;
  assign ent     = (cnt_q == '0) ? '0
                 : (r_wide > (LOG_W+1)'(ENT_MAX)) ? ENT_MAX : r_wide[ENT_W-1:0];
  assign tot_ext = {{TOT_W{1'b0}}, cnt_q};

  // output register
  logic             out_vld_q;
  logic [ENT_W-1:0] out_ent_q;
  logic [TOT_W-1:0] out_tot_q;
  logic             out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ent_q <= ent;
      out_tot_q <= tot_ext[TOT_W-1:0];
      out_ovf_q <= ovf_q;
    end
  end

  assign s_axis_tready_o = cmd_i.pix_en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_tot_q, out_ent_q};
  assign m_axis_tuser_o  = out_ovf_q;

  always_comb begin
    sts_o           = '0;
    sts_o.last_acc  = accept & s_axis_tlast_i;
    sts_o.pipe_busy = p1_vld_q;
    sts_o.n_zero    = (cnt_q == '0);
    sts_o.bin_zero  = (bin_cnt == '0);
    sts_o.idx_last  = (idx_q == BIN_W'(BIN_COUNT - 1));
    sts_o.log_done  = log_done;
    sts_o.div_done  = div_done;
    sts_o.out_full  = out_vld_q;
  end

endmodule

/* rtl/ihe_ctrl.sv */
// controller: frame intake, bin sweep, division and result hand-off
module ihe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ihe_pkg::sts_t sts_i,
  output ihe_pkg::cmd_t cmd_o
);
  import ihe_pkg::*;

  typedef enum logic [3:0] {
    S_PIX, S_DRAIN, S_LOGN, S_LOGN_W, S_RD, S_RDW, S_LOG_W,
    S_MULF, S_ADDF, S_ADDI, S_NEXT, S_DIV, S_DIV_W, S_FIN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_PIX: begin
        cmd_o.pix_en = 1'b1;
        if (sts_i.last_acc) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = sts_i.n_zero ? S_FIN : S_LOGN;
      end
      S_LOGN: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel_n = 1'b1;
        cmd_o.acc_clr   = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d         = S_LOGN_W;
      end
      S_LOGN_W: begin
        if (sts_i.log_done) begin
          cmd_o.save_logn = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: state_d = S_RDW;
      S_RDW: begin
        cmd_o.latch_c = 1'b1;
        if (sts_i.bin_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.log_start = 1'b1;
          state_d         = S_LOG_W;
        end
      end
      S_LOG_W: begin
        if (sts_i.log_done) state_d = S_MULF;
      end
      S_MULF: begin
        cmd_o.mul_frac = 1'b1;
        state_d        = S_ADDF;
      end
      S_ADDF: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_int = 1'b1;
        state_d       = S_ADDI;
      end
      S_ADDI: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_NEXT;
      end
      S_NEXT: begin
        if (sts_i.idx_last) begin
          state_d = S_DIV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_W;
      end
      S_DIV_W: begin
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.frame_clr = 1'b1;
          state_d         = S_PIX;
        end
      end
      default: state_d = S_PIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PIX;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/image_histogram_entropy.sv */
// top level of the histogram entropy block
// Pixels stream in on the slave side at one item per clock while a frame is open;
// each is counted into a BIN_COUNT-bin histogram held in one memory with a
// registered read port, and a one-entry forward path lets the same bin be hit on
// consecutive cycles. Pixel values at or above BIN_COUNT land in the last bin. Once
// 2^MAX_PIXELS_LOG2 pixels are counted, further pixels of the frame are dropped and
// the overflow flag is raised. The item with tlast ends the frame; tready then stays
// low while the entropy is worked out: the pending histogram write is drained, then
// log2(N) is found by leading-zero shifts and one squaring per fraction bit, then a
// sweep over all bins skips each empty bin and, for a filled one, takes log2 of its
// count and adds the count times that log2 to a sum (both log2 steps use the shared
// bit-serial log2 unit), and finally a restoring divide of the sum by N and a load of
// the result. The result item holds the entropy in fixed point with FRACTION_BITS
// fraction bits, 4.16 at default settings (clamped at all ones of its 20 bits), and
// the 21-bit pixel count, with the overflow flag on tuser; it sits in an output
// register, so the next frame may stream in while it waits to be taken. The
// histogram is emptied at once after each frame through per-bin valid bits, so no
// clearing pass is needed after reset.
module image_histogram_entropy #(
  parameter int BIN_COUNT       = ihe_pkg::BIN_COUNT_DEF,
  parameter int MAX_PIXELS_LOG2 = ihe_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int FRACTION_BITS   = ihe_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side: one pixel per item
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [ihe_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] pixel_value
  input  logic                            s_axis_tlast_i,   // last_pixel
  // master side: one result per frame
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ihe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // [19:0] entropy_bits,
                                                            // [40:20] pixel_total, rest 0
  output logic                            m_axis_tuser_o    // count_overflow
);
  import ihe_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: intake, sweep over bins, divide, result hand-off
  ihe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath: histogram, log2 unit, multiply-accumulate, divider, output register
  ihe_dp #(
    .BIN_COUNT       (BIN_COUNT),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/ihe_checker.sv */
// port-level checks for the entropy block and their binding
module ihe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ihe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);
  import ihe_pkg::*;

  // intake closes right after the frame's last item
  a_close_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("intake still open after last item");

  // a fresh result only appears while intake is closed
  a_result_when_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared while a frame was open");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

endmodule

bind image_histogram_entropy ihe_checker u_ihe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
